@@ sv/crc8_tagged_line_checker_defines.svh @@
// Assertion macros shared by the tagged line checker RTL.
`ifndef CRC8_TAGGED_LINE_CHECKER_DEFINES_SVH
`define CRC8_TAGGED_LINE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// Implication in the same cycle, sampled on clk, disabled during reset.
`define CRC8TL_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: label");

// Implication into the next cycle, sampled on clk, disabled during reset.
`define CRC8TL_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: label");

`else

`define CRC8TL_ASSERT_SAME(label, pre, post)
`define CRC8TL_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ sv/crc8tl_pkg.sv @@
// Types, codes and helper functions of the tagged line checker.
`timescale 1ns / 1ps
`default_nettype none

package crc8tl_pkg;

    localparam int unsigned PLEN_W = 11;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SPACE_BYTE   = 8'd32;
    localparam logic [7:0] START_RESET  = 8'h58;
    localparam logic [7:0] POLY_RESET   = 8'h61;

    // Bit 16 of a field word marks a field that can never match.
    localparam logic [16:0] FIELD_BAD   = 17'h10000;

    typedef enum logic [1:0] {
        STATUS_MATCH     = 2'd0,
        STATUS_BAD_START = 2'd1,
        STATUS_NO_FIELD  = 2'd2,
        STATUS_MISMATCH  = 2'd3
    } status_t;

    typedef enum logic {
        CFG_START_CHAR = 1'b0,
        CFG_CRC_POLY   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        status_t             status;
        logic [7:0]          crc;
        logic [PLEN_W-1:0]   len;
    } verdict_t;

    // One byte through the non-reflected CRC-8 shift register.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return ((c >= 8'd48) && (c <= 8'd57)) || ((c >= 8'd65) && (c <= 8'd70));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'd48 + {4'd0, nib}) : (8'd55 + {4'd0, nib});
    endfunction

    // Uppercase hex text of a CRC with no leading zero, as a field word.
    function automatic logic [16:0] crc_text(input logic [7:0] crc);
        logic [16:0] t;
        if (crc[7:4] == 4'd0)
        begin
            t = {9'd0, hex_char(crc[3:0])};
        end
        else
        begin
            t = {1'b0, hex_char(crc[7:4]), hex_char(crc[3:0])};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ sv/crc8tl_line_state.sv @@
// Per-line state: running CRC, space snapshots, field capture and verdict.
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_tagged_line_checker_defines.svh"

module crc8tl_line_state #(
    parameter int unsigned LINE_LENGTH_MAX = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            start_char,
    input  wire logic [7:0]            crc_poly,
    input  wire logic                  byte_accept,
    input  wire logic [7:0]            rx_byte,
    output crc8tl_pkg::verdict_t       verdict
);

    localparam int unsigned POS_W = $clog2(LINE_LENGTH_MAX + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_LENGTH_MAX);

    logic [7:0]       running_crc_reg, running_crc_next;
    logic [7:0]       crc_last_reg, crc_last_next;
    logic [7:0]       crc_prev_reg, crc_prev_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] len_last_reg, len_last_next;
    logic [POS_W-1:0] len_prev_reg, len_prev_next;
    logic [1:0]       space_count_reg, space_count_next;
    logic             start_ok_reg, start_ok_next;
    logic [16:0]      cur_field_reg, cur_field_next;
    logic [16:0]      closed_field_reg, closed_field_next;

    logic is_newline;
    logic is_space;

    assign is_newline = (rx_byte == crc8tl_pkg::NEWLINE_BYTE);
    assign is_space   = (rx_byte == crc8tl_pkg::SPACE_BYTE);

    always_comb
    begin
        running_crc_next  = running_crc_reg;
        crc_last_next     = crc_last_reg;
        crc_prev_next     = crc_prev_reg;
        position_next     = position_reg;
        len_last_next     = len_last_reg;
        len_prev_next     = len_prev_reg;
        space_count_next  = space_count_reg;
        start_ok_next     = start_ok_reg;
        cur_field_next    = cur_field_reg;
        closed_field_next = closed_field_reg;
        if (byte_accept)
        begin
            if (is_newline)
            begin
                running_crc_next  = '0;
                crc_last_next     = '0;
                crc_prev_next     = '0;
                position_next     = '0;
                len_last_next     = '0;
                len_prev_next     = '0;
                space_count_next  = '0;
                start_ok_next     = 1'b0;
                cur_field_next    = '0;
                closed_field_next = '0;
            end
            else
            begin
                if (position_reg == '0)
                begin
                    start_ok_next = (rx_byte == start_char);
                end
                if (is_space)
                begin
                    crc_prev_next     = crc_last_reg;
                    crc_last_next     = running_crc_reg;
                    len_prev_next     = len_last_reg;
                    len_last_next     = position_reg;
                    closed_field_next = cur_field_reg;
                    cur_field_next    = '0;
                    if (space_count_reg < 2'd2)
                    begin
                        space_count_next = space_count_reg + 2'd1;
                    end
                end
                else if (!cur_field_reg[16])
                begin
                    // A third character or a non-hex character spoils the field.
                    if (!crc8tl_pkg::is_hex_char(rx_byte) || (cur_field_reg[15:8] != 8'd0))
                    begin
                        cur_field_next = crc8tl_pkg::FIELD_BAD;
                    end
                    else
                    begin
                        cur_field_next = {1'b0, cur_field_reg[7:0], rx_byte};
                    end
                end
                running_crc_next = crc8tl_pkg::crc8_byte(running_crc_reg, rx_byte, crc_poly);
                if (position_reg < POS_MAX)
                begin
                    position_next = position_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg  <= '0;
            crc_last_reg     <= '0;
            crc_prev_reg     <= '0;
            position_reg     <= '0;
            len_last_reg     <= '0;
            len_prev_reg     <= '0;
            space_count_reg  <= '0;
            start_ok_reg     <= 1'b0;
            cur_field_reg    <= '0;
            closed_field_reg <= '0;
        end
        else
        begin
            running_crc_reg  <= running_crc_next;
            crc_last_reg     <= crc_last_next;
            crc_prev_reg     <= crc_prev_next;
            position_reg     <= position_next;
            len_last_reg     <= len_last_next;
            len_prev_reg     <= len_prev_next;
            space_count_reg  <= space_count_next;
            start_ok_reg     <= start_ok_next;
            cur_field_reg    <= cur_field_next;
            closed_field_reg <= closed_field_next;
        end
    end

    // Verdict for a newline arriving now, taken from the stored line state.
    always_comb
    begin
        verdict.crc = '0;
        verdict.len = '0;
        priority if (!start_ok_reg)
        begin
            verdict.status = crc8tl_pkg::STATUS_BAD_START;
        end
        else if (space_count_reg < 2'd2)
        begin
            verdict.status = crc8tl_pkg::STATUS_NO_FIELD;
        end
        else
        begin
            verdict.crc = crc_prev_reg;
            verdict.len = crc8tl_pkg::PLEN_W'(len_prev_reg);
            verdict.status = (closed_field_reg == crc8tl_pkg::crc_text(crc_prev_reg)) ?
                             crc8tl_pkg::STATUS_MATCH : crc8tl_pkg::STATUS_MISMATCH;
        end
    end

    `CRC8TL_ASSERT_NEXT(a_newline_clears, byte_accept && is_newline, (position_reg == '0) && (space_count_reg == 2'd0) && !start_ok_reg)
    `CRC8TL_ASSERT_SAME(a_space_sat, 1'b1, space_count_reg != 2'd3)
    `CRC8TL_ASSERT_NEXT(a_pos_step, byte_accept && !is_newline && (position_reg < POS_MAX), position_reg == $past(position_reg) + POS_W'(1))

endmodule

`default_nettype wire

@@ sv/crc8tl_out_reg.sv @@
// Result register holding one verdict until the output transaction completes.
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_tagged_line_checker_defines.svh"

module crc8tl_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  crc8tl_pkg::verdict_t       verdict,
    output logic                       can_load,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output crc8tl_pkg::verdict_t       result
);

    logic                 valid_reg, valid_next;
    crc8tl_pkg::verdict_t result_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= verdict;
        end
    end

    `CRC8TL_ASSERT_NEXT(a_load_shows, load, valid_reg)
    `CRC8TL_ASSERT_SAME(a_load_room, load, can_load)

endmodule

`default_nettype wire

@@ sv/crc8_tagged_line_checker.sv @@
// Top level of the CRC-8 tagged line checker.
// Checks text lines of the form "start payload CRC tail" terminated by a newline,
// taking one byte per clock cycle. A newline produces one verdict, registered and
// shown on the output channel the cycle after the byte is accepted; other bytes
// produce nothing. Ordinary bytes are always taken, also while a verdict waits;
// a newline waits only while the previous verdict is still held in the single
// result register. The byte-wise CRC update and field capture are combinational logic.
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_tagged_line_checker_defines.svh"

module crc8_tagged_line_checker #(
    parameter int unsigned LINE_LENGTH_MAX = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [7:0]                         crc_value,
    output logic [crc8tl_pkg::PLEN_W-1:0]      payload_length
);

    logic [7:0] start_char_reg;
    logic [7:0] crc_poly_reg;

    logic                 in_accept;
    logic                 is_newline;
    logic                 can_load;
    crc8tl_pkg::verdict_t verdict;
    crc8tl_pkg::verdict_t result;

    assign cfg_ready  = 1'b1;
    assign is_newline = (rx_byte == crc8tl_pkg::NEWLINE_BYTE);
    assign in_ready   = can_load || !is_newline;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= crc8tl_pkg::START_RESET;
            crc_poly_reg   <= crc8tl_pkg::POLY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (crc8tl_pkg::cfg_index_t'(cfg_index))
                crc8tl_pkg::CFG_START_CHAR: start_char_reg <= cfg_data;
                crc8tl_pkg::CFG_CRC_POLY:   crc_poly_reg   <= cfg_data;
                default:                    start_char_reg <= start_char_reg;
            endcase
        end
    end

    crc8tl_line_state #(
        .LINE_LENGTH_MAX (LINE_LENGTH_MAX)
    ) u_line_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_char  (start_char_reg),
        .crc_poly    (crc_poly_reg),
        .byte_accept (in_accept),
        .rx_byte     (rx_byte),
        .verdict     (verdict)
    );

    crc8tl_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept && is_newline),
        .verdict   (verdict),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign status         = result.status;
    assign crc_value      = result.crc;
    assign payload_length = result.len;

    `CRC8TL_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready && is_newline)
    `CRC8TL_ASSERT_NEXT(a_byte_no_result, in_accept && !is_newline && !out_valid, !out_valid)

endmodule

`default_nettype wire

@@ bench/crc8_tagged_line_checker_tb.sv @@
// Self-checking testbench for the CRC-8 tagged line checker with random traffic and stalls.
`timescale 1ns / 1ps

module crc8_tagged_line_checker_tb;

    localparam int LINE_MAX = 1024;

    typedef enum int {
        LN_GOOD,
        LN_BAD_START,
        LN_ONE_SPACE,
        LN_NO_SPACE,
        LN_WRONG_TAG,
        LN_LOWER,
        LN_LEAD_ZERO,
        LN_THREE_CHAR,
        LN_EMPTY_TAG,
        LN_NOISE
    } line_kind_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_index = crc8tl_pkg::CFG_START_CHAR;
    logic [7:0]                      cfg_data = 8'd0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      rx_byte = 8'd0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      status;
    logic [7:0]                      crc_value;
    logic [crc8tl_pkg::PLEN_W-1:0]   payload_length;

    crc8_tagged_line_checker #(
        .LINE_LENGTH_MAX(LINE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .crc_value(crc_value),
        .payload_length(payload_length)
    );

    // Bytes waiting to be sent and verdicts waiting to come out.
    logic [7:0]              tx_bytes[$];
    crc8tl_pkg::verdict_t    verdict_q[$];

    // Register copies as the checker sees them.
    logic [7:0]  cur_start = crc8tl_pkg::START_RESET;
    logic [7:0]  cur_poly = crc8tl_pkg::POLY_RESET;

    // Line tracking state of the predictor.
    logic [7:0]                      line_crc = 8'd0;
    logic [7:0]                      crc_snap_last = 8'd0;
    logic [7:0]                      crc_snap_prev = 8'd0;
    logic [crc8tl_pkg::PLEN_W-1:0]   line_pos = '0;
    logic [crc8tl_pkg::PLEN_W-1:0]   pos_snap_last = '0;
    logic [crc8tl_pkg::PLEN_W-1:0]   pos_snap_prev = '0;
    logic [1:0]                      spaces_seen = 2'd0;
    logic                            first_ok = 1'b0;
    logic [16:0]                     field_open = 17'd0;
    logic [16:0]                     field_closed = 17'd0;

    logic  in_fire = 1'b0;
    logic  idling_on = 1'b1;
    logic  long_hold_req = 1'b0;
    logic  long_hold_done = 1'b0;
    int    hold_left = 0;
    int    rx_stall = 0;
    int    tx_gap = 0;
    int    fails = 0;
    int    bytes_taken = 0;
    int    bytes_queued = 0;
    int    verdicts_checked = 0;
    int    cfg_writes = 0;
    int    status_seen[4] = '{0, 0, 0, 0};

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ poly;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'd48 + {4'd0, nib}) : (8'd55 + {4'd0, nib});
    endfunction

    function automatic bit hex_ok(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70);
    endfunction

    // Field word of a CRC written as uppercase hex with no leading zero.
    function automatic logic [16:0] tag_word(input logic [7:0] crc);
        if (crc < 8'd16)
            return {9'd0, hex_digit(crc[3:0])};
        return {1'b0, hex_digit(crc[7:4]), hex_digit(crc[3:0])};
    endfunction

    function automatic logic [7:0] text_byte(input bit allow_space);
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == crc8tl_pkg::NEWLINE_BYTE || (!allow_space && v == crc8tl_pkg::SPACE_BYTE));
        return v;
    endfunction

    // Advances the line state by one accepted byte and queues the verdict on a newline.
    task automatic track_byte(input logic [7:0] b);
        crc8tl_pkg::verdict_t v;
        if (b == crc8tl_pkg::NEWLINE_BYTE)
        begin
            v = '0;
            if (!first_ok)
                v.status = crc8tl_pkg::STATUS_BAD_START;
            else if (spaces_seen < 2'd2)
                v.status = crc8tl_pkg::STATUS_NO_FIELD;
            else
            begin
                v.crc = crc_snap_prev;
                v.len = pos_snap_prev;
                v.status = (field_closed == tag_word(crc_snap_prev)) ?
                           crc8tl_pkg::STATUS_MATCH : crc8tl_pkg::STATUS_MISMATCH;
            end
            verdict_q.push_back(v);
            line_crc = 8'd0;
            crc_snap_last = 8'd0;
            crc_snap_prev = 8'd0;
            line_pos = '0;
            pos_snap_last = '0;
            pos_snap_prev = '0;
            spaces_seen = 2'd0;
            first_ok = 1'b0;
            field_open = 17'd0;
            field_closed = 17'd0;
        end
        else
        begin
            if (line_pos == '0)
                first_ok = (b == cur_start);
            if (b == crc8tl_pkg::SPACE_BYTE)
            begin
                crc_snap_prev = crc_snap_last;
                crc_snap_last = line_crc;
                pos_snap_prev = pos_snap_last;
                pos_snap_last = line_pos;
                field_closed = field_open;
                field_open = 17'd0;
                if (spaces_seen < 2'd2)
                    spaces_seen++;
            end
            else if (!field_open[16])
            begin
                // A third character or any non-hex byte spoils the field for good.
                if (!hex_ok(b) || field_open >= 17'h100)
                    field_open = crc8tl_pkg::FIELD_BAD;
                else
                    field_open = {1'b0, field_open[7:0], b};
            end
            line_crc = crc8_next(line_crc, b, cur_poly);
            if (line_pos < crc8tl_pkg::PLEN_W'(LINE_MAX))
                line_pos++;
        end
    endtask

    // Builds one line of the given shape under the current register values, or a burst of noise bytes.
    task automatic queue_line(input line_kind_t kind, input int body_len);
        logic [7:0]  body[$];
        logic [7:0]  tag[$];
        logic [7:0]  first;
        logic [7:0]  crc;
        logic [16:0] word;
        int          n;
        int          q0;
        if (kind == LN_NOISE)
        begin
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: tx_bytes.push_back(crc8tl_pkg::NEWLINE_BYTE);
                    1: tx_bytes.push_back(crc8tl_pkg::SPACE_BYTE);
                    default: tx_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            bytes_queued += n;
            return;
        end
        first = cur_start;
        if (kind == LN_BAD_START)
        begin
            while (first == cur_start || first == crc8tl_pkg::NEWLINE_BYTE)
                first = 8'($urandom_range(0, 255));
        end
        body.push_back(first);
        repeat (body_len)
            body.push_back(($urandom_range(0, 11) == 0) ? crc8tl_pkg::SPACE_BYTE
                                                         : text_byte(1'b0));
        crc = 8'd0;
        foreach (body[i])
            crc = crc8_next(crc, body[i], cur_poly);
        word = (kind == LN_WRONG_TAG) ? tag_word(crc ^ 8'($urandom_range(1, 255)))
                                      : tag_word(crc);
        if (kind == LN_LEAD_ZERO)
            tag.push_back(hex_digit(4'd0));
        if (kind != LN_EMPTY_TAG)
        begin
            if (word[15:8] != 8'd0)
                tag.push_back(word[15:8]);
            tag.push_back(word[7:0]);
        end
        if (kind == LN_THREE_CHAR)
            tag.push_back(hex_digit(4'($urandom_range(0, 15))));
        if (kind == LN_LOWER)
        begin
            foreach (tag[i])
                if (tag[i] >= 8'd65 && tag[i] <= 8'd70)
                    tag[i] = tag[i] + 8'd32;
        end
        q0 = tx_bytes.size();
        foreach (body[i])
            tx_bytes.push_back(body[i]);
        if (kind != LN_NO_SPACE)
            tx_bytes.push_back(crc8tl_pkg::SPACE_BYTE);
        foreach (tag[i])
            tx_bytes.push_back(tag[i]);
        if (kind != LN_NO_SPACE && kind != LN_ONE_SPACE)
        begin
            tx_bytes.push_back(crc8tl_pkg::SPACE_BYTE);
            n = $urandom_range(0, 4);
            repeat (n)
                tx_bytes.push_back(text_byte(1'b0));
        end
        tx_bytes.push_back(crc8tl_pkg::NEWLINE_BYTE);
        bytes_queued += tx_bytes.size() - q0;
    endtask

    function automatic line_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return LN_GOOD;
        if (r < 64) return LN_BAD_START;
        if (r < 68) return LN_ONE_SPACE;
        if (r < 71) return LN_NO_SPACE;
        if (r < 77) return LN_WRONG_TAG;
        if (r < 81) return LN_LOWER;
        if (r < 85) return LN_LEAD_ZERO;
        if (r < 89) return LN_THREE_CHAR;
        if (r < 92) return LN_EMPTY_TAG;
        return LN_NOISE;
    endfunction

    // Mostly short payloads, now and then a longer one of 13 to 80 body bytes.
    task automatic queue_random(input int budget);
        int stop_at;
        stop_at = bytes_queued + budget;
        while (bytes_queued < stop_at)
            queue_line(pick_kind(), ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                                 : $urandom_range(0, 12));
    endtask

    // Waits until every queued byte is taken and every verdict has been checked.
    task automatic settle();
        while (bytes_taken != bytes_queued || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input crc8tl_pkg::cfg_index_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Byte sender: holds each byte until its transaction completes, with random gaps.
    always @(negedge clk)
    begin : byte_sender
        logic keep;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            keep = in_valid && !in_fire;
            if (!keep)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    rx_byte <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (idling_on && $urandom_range(0, 4) == 0)
                        tx_gap = $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict receiver: random stall bursts plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        crc8tl_pkg::verdict_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                if (cfg_index == crc8tl_pkg::CFG_START_CHAR)
                    cur_start = cfg_data;
                else
                    cur_start = cur_start;
                if (cfg_index == crc8tl_pkg::CFG_CRC_POLY)
                    cur_poly = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected verdict: status %0d crc_value %0d payload_length %0d",
                           status, crc_value, payload_length);
                    fails++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                    if (crc_value !== want.crc)
                    begin
                        $error("crc_value: expected %0d, got %0d", want.crc, crc_value);
                        fails++;
                    end
                    if (payload_length !== want.len)
                    begin
                        $error("payload_length: expected %0d, got %0d", want.len,
                               payload_length);
                        fails++;
                    end
                    status_seen[want.status]++;
                    verdicts_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                track_byte(rx_byte);
                bytes_taken++;
            end
        end
        in_fire <= rst_n && in_valid && in_ready;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines under the reset register values.
        tx_bytes.push_back(crc8tl_pkg::NEWLINE_BYTE);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(crc8tl_pkg::SPACE_BYTE);
        tx_bytes.push_back(crc8tl_pkg::NEWLINE_BYTE);
        bytes_queued += 4;
        queue_line(LN_ONE_SPACE, 0);
        queue_line(LN_GOOD, 0);
        queue_line(LN_EMPTY_TAG, 0);
        queue_line(LN_THREE_CHAR, 0);
        queue_random(220);
        settle();

        // Both registers at zero; the receiver holds off while lines keep arriving.
        write_reg(crc8tl_pkg::CFG_START_CHAR, 8'h00);
        write_reg(crc8tl_pkg::CFG_CRC_POLY, 8'h00);
        queue_random(200);
        long_hold_req <= 1'b1;
        settle();

        // Both registers at all ones.
        write_reg(crc8tl_pkg::CFG_START_CHAR, 8'hFF);
        write_reg(crc8tl_pkg::CFG_CRC_POLY, 8'hFF);
        queue_random(100);
        queue_random(100);
        settle();

        // A newline as start character can never begin a line.
        write_reg(crc8tl_pkg::CFG_START_CHAR, crc8tl_pkg::NEWLINE_BYTE);
        write_reg(crc8tl_pkg::CFG_CRC_POLY, 8'h07);
        queue_random(100);
        settle();

        // Random registers, then a closing stretch with no idling on either side.
        write_reg(crc8tl_pkg::CFG_CRC_POLY, 8'($urandom_range(0, 255)));
        write_reg(crc8tl_pkg::CFG_START_CHAR, text_byte(1'b1));
        queue_random(150);
        settle();
        idling_on <= 1'b0;
        queue_random(150);
        settle();

        $display("Covered %0d bytes and %0d verdicts over %0d register writes.",
                 bytes_taken, verdicts_checked, cfg_writes);
        $display("Verdicts by status: match %0d, bad start %0d, no field %0d, mismatch %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
